// ----- rtl/core/hde_pkg.sv -----
// ----------------------------------------------------------------------------
// hde_pkg - haptic detent engine shared definitions
// Word types, configuration layout, register indexes and the fixed tables
// used by the front stage and the torque pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hde_pkg;

    // Defaults for the top-level parameters
    localparam int ANGLE_BITS_DEF  = 24;
    localparam int LPF_SHIFT_DEF   = 3;
    localparam int COOLDOWN_MS_DEF = 50;

    // Sensor angle width, scaled up to the internal angle width
    localparam int RAW_BITS = 12;

    // Largest scroll step per tick
    localparam int MAX_STEP = 8;

    // Acceleration thresholds: floor(256 * (exp(k / 4) - 1)), k = 1..MAX_STEP
    localparam logic [10:0] ACCEL_ROM [1:MAX_STEP] = '{
        11'd72, 11'd166, 11'd285, 11'd439, 11'd637, 11'd891, 11'd1217, 11'd1635
    };

    // 2*pi in Q13
    localparam int TWO_PI_Q13 = 51472;

    // Kick scaling: kick_level * (speed + KICK_OFFSET) / 2560, done as >>9
    // then multiply by ceil(2^21 / 5) and >>21 (exact over the 19-bit range)
    localparam int KICK_OFFSET      = 1280;
    localparam int KICK_PRE_SHIFT   = 9;
    localparam int KICK_RECIP       = 419431;
    localparam int KICK_RECIP_SHIFT = 21;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_DETENT_SIZE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS_MARGIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTION_THRESHOLD  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_DEADZONE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRING_GAIN       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING_GAIN      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_KICK_LEVEL        = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_LIMIT      = 3'd7;

    typedef struct packed {
        logic [23:0] detent_size;
        logic [22:0] hysteresis_margin;
        logic [14:0] motion_threshold;
        logic [14:0] rate_deadzone;
        logic [15:0] spring_gain;
        logic [15:0] damping_gain;
        logic [10:0] kick_level;
        logic [10:0] torque_limit;
    } hde_cfg_t;

    localparam hde_cfg_t CFG_RESET = '{
        detent_size:       24'd699051,
        hysteresis_margin: 23'd46603,
        motion_threshold:  15'd128,
        rate_deadzone:     15'd64,
        spring_gain:       16'd1024,
        damping_gain:      16'd256,
        kick_level:        11'd384,
        torque_limit:      11'd768
    };

    typedef struct packed {
        logic [11:0]        raw_angle;
        logic signed [15:0] spin_rate;
        logic [31:0]        now_ms;
    } hde_in_t;

    typedef struct packed {
        logic signed [4:0]  wheel_delta;
        logic signed [11:0] torque;
        logic               kick_fired;
    } hde_out_t;

    // Front stage to torque pipeline
    typedef struct packed {
        logic signed [4:0] wheel_delta;
        logic              torque_on;   // moving and outside the snap zone
        logic              err_pos;     // error strictly positive
        logic              fv_pos;      // deadbanded velocity > 0
        logic              fv_neg;      // deadbanded velocity < 0
        logic              same_sign;   // velocity and error agree
        logic              kick_fire;
        logic [15:0]       drive_speed; // deadbanded speed
    } hde_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/hde_front.sv -----
// ----------------------------------------------------------------------------
// hde_front - filters, detent stepping and kick decision
// Holds all loop state and updates it for each accepted word; hands the
// torque pipeline the error magnitude and control flags.
// ----------------------------------------------------------------------------
`default_nettype none

module hde_front
    import hde_pkg::*;
#(
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
    parameter int LPF_SHIFT   = LPF_SHIFT_DEF,
    parameter int COOLDOWN_MS = COOLDOWN_MS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hde_cfg_t              cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire hde_in_t               in_word,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output hde_ctl_t                   ctl,
    output logic [ANGLE_BITS-1:0]      aerr
);

    localparam int AB = ANGLE_BITS;
    localparam int CW = ((AB > 24) ? AB : 24) + 3;  // step compare width
    localparam int KW = ((AB > 24) ? AB : 24) + 7;  // kick zone compare width

    logic [AB-1:0]        fa_reg, fa_next;
    logic signed [15:0]   fv_reg, fv_next;
    logic [AB-1:0]        center_reg, center_next;
    logic                 kick_active_reg, kick_active_next;
    logic [31:0]          last_kick_reg, last_kick_next;
    logic                 valid_reg;
    hde_ctl_t             ctl_reg, ctl_next;
    logic [AB-1:0]        aerr_reg, aerr_next;

    logic                 take;
    logic [AB-1:0]        raw_s, adiff, err1, err2, ds_ab;
    logic signed [16:0]   vdiff, vstep, fv_sum, fv_mag;
    logic [15:0]          speed, drive_speed;
    logic                 moving, step_up, step_dn, in_db, err_neg, err_pos;
    logic                 fv_pos, fv_neg, kick_held, torque_on, kick_zone, fire;
    logic signed [CW-1:0] two_err, step_thr;
    logic [4:0]           acc, step_mag, wheel_mag;
    logic signed [4:0]    wheel;
    logic [KW-1:0]        aerr_k, ds_k;
    logic [31:0]          elapsed;

    assign take     = in_valid && in_ready;
    assign in_ready = !valid_reg || out_ready;

    // Low-pass filters; arithmetic shift gives round toward minus infinity
    always_comb
    begin
        raw_s   = AB'(in_word.raw_angle) << (AB - RAW_BITS);
        adiff   = raw_s - fa_reg;
        fa_next = fa_reg + AB'($signed(adiff) >>> LPF_SHIFT);

        vdiff   = 17'(in_word.spin_rate) - 17'(fv_reg);
        vstep   = vdiff >>> LPF_SHIFT;
        fv_sum  = 17'(fv_reg) + vstep;
        fv_next = fv_sum[15:0];
        fv_mag  = fv_next[15] ? -17'(fv_next) : 17'(fv_next);
        speed   = fv_mag[15:0];
    end

    // Acceleration: highest threshold the speed reaches
    always_comb
    begin
        acc = '0;
        for (int k = 1; k <= MAX_STEP; k++)
        begin
            if (speed >= 16'(ACCEL_ROM[k]))
            begin
                acc = 5'(k);
            end
        end
        step_mag  = acc + 5'd1;
        wheel_mag = (step_mag > 5'(MAX_STEP)) ? 5'(MAX_STEP) : step_mag;
    end

    // Detent step
    always_comb
    begin
        err1     = fa_next - center_reg;
        two_err  = CW'($signed(err1)) <<< 1;
        step_thr = CW'(cfg.detent_size) + (CW'(cfg.hysteresis_margin) << 1);
        moving   = speed >= 16'(cfg.motion_threshold);
        step_up  = moving && (two_err > step_thr);
        step_dn  = moving && (two_err < -step_thr);
        ds_ab    = AB'(cfg.detent_size);

        if (step_up)
        begin
            wheel       = $signed(wheel_mag);
            center_next = center_reg + ds_ab;
        end
        else if (step_dn)
        begin
            wheel       = -$signed(wheel_mag);
            center_next = center_reg - ds_ab;
        end
        else
        begin
            wheel       = '0;
            center_next = center_reg;
        end
    end

    // Haptic decisions against the updated centre
    always_comb
    begin
        err2        = fa_next - center_next;
        err_neg     = err2[AB-1];
        err_pos     = !err_neg && (err2 != '0);
        aerr_next   = err_neg ? -err2 : err2;

        in_db       = speed < 16'(cfg.rate_deadzone);
        drive_speed = in_db ? 16'd0 : speed;
        fv_pos      = !in_db && !fv_next[15] && (fv_next != '0);
        fv_neg      = !in_db && fv_next[15];

        elapsed     = in_word.now_ms - last_kick_reg;
        kick_held   = kick_active_reg && (elapsed < 32'(COOLDOWN_MS));

        torque_on   = (drive_speed > 16'(cfg.motion_threshold)) &&
                      (CW'(aerr_next) >= CW'(cfg.hysteresis_margin));

        // 3*ds < 8*|err| and 40*|err| < 19*ds
        aerr_k      = KW'(aerr_next);
        ds_k        = KW'(cfg.detent_size);
        kick_zone   = ((aerr_k << 3) > ((ds_k << 1) + ds_k)) &&
                      (((aerr_k << 5) + (aerr_k << 3)) <
                       ((ds_k << 4) + (ds_k << 1) + ds_k));
        fire        = torque_on && !kick_held && kick_zone;

        kick_active_next = fire || kick_held;
        last_kick_next   = fire ? in_word.now_ms : last_kick_reg;

        ctl_next.wheel_delta = wheel;
        ctl_next.torque_on   = torque_on;
        ctl_next.err_pos     = err_pos;
        ctl_next.fv_pos      = fv_pos;
        ctl_next.fv_neg      = fv_neg;
        ctl_next.same_sign   = (fv_pos && err_pos) || (fv_neg && err_neg);
        ctl_next.kick_fire   = fire;
        ctl_next.drive_speed = drive_speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_reg          <= '0;
            fv_reg          <= '0;
            center_reg      <= '0;
            kick_active_reg <= 1'b0;
            last_kick_reg   <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                fa_reg          <= fa_next;
                fv_reg          <= fv_next;
                center_reg      <= center_next;
                kick_active_reg <= kick_active_next;
                last_kick_reg   <= last_kick_next;
            end
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctl_reg  <= ctl_next;
            aerr_reg <= aerr_next;
        end
    end

    assign out_valid = valid_reg;
    assign ctl       = ctl_reg;
    assign aerr      = aerr_reg;

endmodule

`default_nettype wire

// ----- rtl/core/hde_torque.sv -----
// ----------------------------------------------------------------------------
// hde_torque - spring, damping and kick torque pipeline
// Three stages: products, scaling, then sum, motion gating and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module hde_torque
    import hde_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hde_cfg_t              cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire hde_ctl_t              ctl,
    input  wire logic [ANGLE_BITS-1:0] aerr,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output hde_out_t                   out_word
);

    localparam int AB = ANGLE_BITS;
    localparam int SW = AB + 16;   // spring_gain * |err|
    localparam int PW = AB + 32;   // times 2*pi
    localparam int TW = 26;        // torque sum width

    logic            v2_reg, v3_reg, v4_reg;
    logic            rdy2, rdy3, rdy4;

    hde_ctl_t        ctl2_reg, ctl3_reg;
    logic [SW-1:0]   sprod_reg;
    logic [31:0]     dprod_reg;
    logic [27:0]     kprod_reg;

    logic [PW-1:0]   spring_full;
    logic [18:0]     spring_next, spring_reg;
    logic [23:0]     dmag_next, dmag_reg;
    logic [18:0]     kq_in;
    logic [39:0]     kq_full;
    logic [18:0]     kq;
    logic [10:0]     kick_next, kick_reg;

    logic signed [TW-1:0] sp_s, dm_s, kk_s, lim_s, tq;
    hde_out_t        out_next, out_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    // Scaling stage
    always_comb
    begin
        spring_full = PW'(sprod_reg) * PW'(TWO_PI_Q13);
        spring_next = spring_full[PW-1:AB+13];
        dmag_next   = ctl2_reg.same_sign ? dprod_reg[31:8] : 24'(dprod_reg[31:9]);
        kq_in       = kprod_reg[27:KICK_PRE_SHIFT];
        kq_full     = 40'(kq_in) * 40'(KICK_RECIP);
        kq          = kq_full[39:KICK_RECIP_SHIFT];
        kick_next   = (kq > 19'(cfg.kick_level)) ? cfg.kick_level : kq[10:0];
    end

    // Sum with kick, gate against motion, clamp, and zero unless torque_on
    always_comb
    begin
        sp_s  = TW'(spring_reg);
        dm_s  = TW'(dmag_reg);
        kk_s  = TW'(kick_reg);
        lim_s = TW'(cfg.torque_limit);

        tq = (ctl3_reg.err_pos ? sp_s : -sp_s) - (ctl3_reg.fv_neg ? -dm_s : dm_s);
        if (ctl3_reg.kick_fire)
        begin
            tq = tq + (ctl3_reg.err_pos ? kk_s : -kk_s);
        end
        if ((ctl3_reg.fv_pos && (tq < 0)) || (ctl3_reg.fv_neg && (tq > 0)))
        begin
            tq = '0;
        end
        if (tq > lim_s)
        begin
            tq = lim_s;
        end
        if (tq < -lim_s)
        begin
            tq = -lim_s;
        end
        if (!ctl3_reg.torque_on)
        begin
            tq = '0;
        end

        out_next.wheel_delta = ctl3_reg.wheel_delta;
        out_next.torque      = tq[11:0];
        out_next.kick_fired  = ctl3_reg.kick_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= in_valid;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && in_valid)
        begin
            ctl2_reg  <= ctl;
            sprod_reg <= SW'(cfg.spring_gain) * SW'(aerr);
            dprod_reg <= 32'(cfg.damping_gain) * 32'(ctl.drive_speed);
            kprod_reg <= 28'(cfg.kick_level) *
                         28'(17'(ctl.drive_speed) + 17'(KICK_OFFSET));
        end
        if (rdy3 && v2_reg)
        begin
            ctl3_reg   <= ctl2_reg;
            spring_reg <= spring_next;
            dmag_reg   <= dmag_next;
            kick_reg   <= kick_next;
        end
        if (rdy4 && v3_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_word  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/haptic_detent_engine_top.sv -----
// ----------------------------------------------------------------------------
// haptic_detent_engine_top - knob detent engine, one control tick per word
// Input register, configuration registers, front stage and torque pipeline.
// ----------------------------------------------------------------------------
// One input word is one control tick: sensor angle, shaft velocity and the
// millisecond clock. The block takes one word every clock cycle while the
// output is not stalled and returns exactly one result word (wheel delta,
// drive torque, kick flag) per input word, in order, once it has passed the
// input register, the front stage and the torque pipeline. The rate is set
// by the front stage, which updates the filter, detent centre and kick state
// of each tick as it accepts it, so the next tick can follow straight away;
// the torque multiplies run behind it in a three-stage pipeline. Each stage
// has its own valid bit and ready; gaps close up while the output waits.
// Configuration registers are written through cfg_we/cfg_index/cfg_data at
// any edge with cfg_we high; write them only while the block is empty.
`default_nettype none

module haptic_detent_engine_top
    import hde_pkg::*;
#(
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF,   // internal angle, 16..32
    parameter int LPF_SHIFT   = LPF_SHIFT_DEF,    // filter alpha 2^-LPF_SHIFT
    parameter int COOLDOWN_MS = COOLDOWN_MS_DEF   // kick re-arm time
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire hde_in_t                in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output hde_out_t                    out_data
);

    hde_cfg_t                cfg_reg;

    // Input register
    logic                    s0_valid_reg;
    hde_in_t                 s0_word_reg;
    logic                    front_ready;

    // Front stage to torque pipeline
    logic                    front_valid;
    logic                    torque_ready;
    hde_ctl_t                front_ctl;
    logic [ANGLE_BITS-1:0]   front_aerr;

    assign in_ready = !s0_valid_reg || front_ready;

    // Configuration registers: narrower ones keep the low bits of the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DETENT_SIZE:       cfg_reg.detent_size       <= cfg_data;
                REG_HYSTERESIS_MARGIN: cfg_reg.hysteresis_margin <= cfg_data[22:0];
                REG_MOTION_THRESHOLD:  cfg_reg.motion_threshold  <= cfg_data[14:0];
                REG_RATE_DEADZONE:     cfg_reg.rate_deadzone     <= cfg_data[14:0];
                REG_SPRING_GAIN:       cfg_reg.spring_gain       <= cfg_data[15:0];
                REG_DAMPING_GAIN:      cfg_reg.damping_gain      <= cfg_data[15:0];
                REG_KICK_LEVEL:        cfg_reg.kick_level        <= cfg_data[10:0];
                REG_TORQUE_LIMIT:      cfg_reg.torque_limit      <= cfg_data[10:0];
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s0_word_reg <= in_data;
        end
    end

    // Loop state, filters, stepping and kick decision
    hde_front #(
        .ANGLE_BITS  (ANGLE_BITS),
        .LPF_SHIFT   (LPF_SHIFT),
        .COOLDOWN_MS (COOLDOWN_MS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s0_valid_reg),
        .in_ready  (front_ready),
        .in_word   (s0_word_reg),
        .out_valid (front_valid),
        .out_ready (torque_ready),
        .ctl       (front_ctl),
        .aerr      (front_aerr)
    );

    // Spring, damping, kick and clamp
    hde_torque #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_torque (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (front_valid),
        .in_ready  (torque_ready),
        .ctl       (front_ctl),
        .aerr      (front_aerr),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_data)
    );

endmodule

`default_nettype wire
